// ===== src/imu_frame_deframer_defines.svh =====
// Assertion macros shared by the deframer RTL files.
// Depends on nothing; included by the files that carry assertions.
`ifndef IMU_FRAME_DEFRAMER_DEFINES_SVH
`define IMU_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IMU_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IMU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/imu_fd_pkg.sv =====
// Shared types, constants and helper functions of the IMU frame deframer.
// Depends on nothing; used by every module of the block.
package imu_fd_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACC   = 8'h51;
    localparam logic [7:0] TYPE_GYRO  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    localparam int AXIS_BYTES = 6;

    // Frame byte positions: hunting, type byte, first axis byte, checksum byte.
    localparam logic [3:0] POS_HUNT  = 4'd0;
    localparam logic [3:0] POS_TYPE  = 4'd1;
    localparam logic [3:0] POS_AXIS0 = 4'd2;
    localparam logic [3:0] POS_LAST  = 4'd10;

    typedef enum logic [1:0] {
        KIND_ACC   = 2'd0,
        KIND_GYRO  = 2'd1,
        KIND_ANGLE = 2'd2
    } kind_t;

    typedef struct packed {
        logic signed [15:0] axis_z;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_x;
        kind_t              kind;
    } result_t;

    // Two's complement negation that maps the most negative code to the largest positive one.
    function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
        logic signed [15:0] r;
        if (v == 16'sh8000) begin
            r = 16'sh7FFF;
        end else begin
            r = -v;
        end
        return r;
    endfunction

endpackage

// ===== src/imu_fd_in_stage.sv =====
// Input register of the IMU frame deframer: holds one received byte.
// Depends on imu_fd_pkg.
module imu_fd_in_stage
    import imu_fd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       consume,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The register can take a new word when it is empty or emptied this cycle.
    assign s_tready   = !valid_reg || consume;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

// ===== src/imu_fd_parser.sv =====
// Frame tracker of the IMU frame deframer: byte position, checksum, captured fields,
// and the decode of a finished frame into one result. Depends on imu_fd_pkg and the
// assertion macros in imu_frame_deframer_defines.svh.
`include "imu_frame_deframer_defines.svh"
module imu_fd_parser
    import imu_fd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    output logic       res_valid,
    output result_t    res
);

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] type_reg;
    logic [7:0] axis_reg [AXIS_BYTES];

    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;

    always_comb begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (byte_valid) begin
            if (pos_reg == POS_HUNT) begin
                if (byte_data == HDR_BYTE) begin
                    pos_next = POS_TYPE;
                    sum_next = byte_data;
                end
            end else if (pos_reg == POS_LAST) begin
                pos_next = POS_HUNT;
            end else begin
                pos_next = pos_reg + 4'd1;
                sum_next = sum_reg + byte_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HUNT;
            sum_reg <= 8'd0;
        end else begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // Field capture; these registers are always written before a frame is judged.
    always_ff @(posedge aclk) begin
        if (byte_valid && pos_reg == POS_TYPE) begin
            type_reg <= byte_data;
        end
        for (int i = 0; i < AXIS_BYTES; i++) begin
            if (byte_valid && pos_reg == POS_AXIS0 + 4'(i)) begin
                axis_reg[i] <= byte_data;
            end
        end
    end

    assign raw_x = {axis_reg[1], axis_reg[0]};
    assign raw_y = {axis_reg[3], axis_reg[2]};
    assign raw_z = {axis_reg[5], axis_reg[4]};

    always_comb begin
        res_valid  = 1'b0;
        res.kind   = KIND_ACC;
        res.axis_x = neg_sat(raw_y);
        res.axis_y = neg_sat(raw_x);
        res.axis_z = raw_z;
        if (byte_valid && pos_reg == POS_LAST && byte_data == sum_reg) begin
            unique case (type_reg)
                TYPE_ACC: begin
                    res_valid = 1'b1;
                    res.kind  = KIND_ACC;
                end
                TYPE_GYRO: begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_GYRO;
                    res.axis_z = neg_sat(raw_z);
                end
                TYPE_ANGLE: begin
                    res_valid = 1'b1;
                    res.kind  = KIND_ANGLE;
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    `IMU_ASSERT_IMPL(a_pos_range, aclk, aresetn, 1'b1, pos_reg <= POS_LAST, "byte position out of range")
    `IMU_ASSERT_IMPL(a_res_at_end, aclk, aresetn, res_valid, byte_valid && pos_reg == POS_LAST && byte_data == sum_reg, "result outside a frame end")
    `IMU_ASSERT_NEXT(a_end_hunts, aclk, aresetn, byte_valid && pos_reg == POS_LAST, pos_reg == POS_HUNT, "no return to hunting after a frame")
    `IMU_ASSERT_NEXT(a_hunt_drop, aclk, aresetn, byte_valid && pos_reg == POS_HUNT && byte_data != HDR_BYTE, pos_reg == POS_HUNT, "frame started without a header")

endmodule

// ===== src/imu_fd_out_stage.sv =====
// Result register of the IMU frame deframer, drained by the master-side stream.
// Depends on imu_fd_pkg.
module imu_fd_out_stage
    import imu_fd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    res_valid,
    input  result_t res,
    output logic    free,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Free when empty or when the held word leaves this cycle.
    assign free       = !valid_reg || m_tready;
    assign valid_next = free ? res_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

// ===== src/imu_frame_deframer.sv =====
// IMU frame deframer: turns a received byte stream into acceleration, angular rate
// and angle results. Depends on imu_fd_pkg, imu_fd_in_stage, imu_fd_parser, imu_fd_out_stage.
//
// Usage: each word on the slave side carries one received byte in s_tdata. The block
// drops bytes until the header 0x55, then takes the ten following bytes as a frame:
// type, six little-endian axis bytes, two unused bytes and an 8-bit sum checksum over
// the first ten bytes. A frame with a good checksum and type 0x51, 0x52 or 0x53 gives
// one word on the master side; any other frame is dropped without notice.
// The master word carries the remapped axes in m_tdata and the result kind in m_tuser.
// A result word reaches m_tvalid through the input register, which holds the checksum
// byte, and then the result register, which is loaded with the decoded frame.
// Throughput: one byte per cycle while the result register can take a new word; the
// byte position and running checksum are updated between the input register and the
// result register.
// Reset (aresetn low at a rising edge) empties both registers and returns the block to
// hunting with a cleared checksum; no memory clearing pass is needed.
// When the receiver stalls, the held result stays stable; the block keeps one byte in
// its input register and then holds s_tready low until the result word is taken.
module imu_frame_deframer
    import imu_fd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] axis_x, [31:16] axis_y, [47:32] axis_z
    output logic [1:0]  m_tuser    // [1:0] kind
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       consume;
    logic       free;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    // A byte moves from the input register through the frame logic whenever the
    // result register can take whatever it produces.
    assign consume = byte_valid && free;

    imu_fd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .consume    (consume),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    imu_fd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (consume),
        .byte_data  (byte_data),
        .res_valid  (res_valid),
        .res        (res)
    );

    imu_fd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .free      (free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = {m_res.axis_z, m_res.axis_y, m_res.axis_x};
    assign m_tuser = m_res.kind;

endmodule
